@@ rtl/assert_macros.svh @@
// Assertion macros shared by the parser RTL.
// Included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`endif

@@ rtl/lrc_pkg.sv @@
// Package for the LRC timestamp line parser: constants, types and byte helpers.
// No dependencies.
`timescale 1ns / 1ps
package lrc_pkg;
    localparam int MaxLineLen = 255;
    localparam int LineCountWidth = 16;
    localparam int PosW = 8;
    localparam int QDepth = 2;

    localparam logic [2:0] PH_LEAD = 3'd0;
    localparam logic [2:0] PH_FIRST = 3'd1;
    localparam logic [2:0] PH_MIN = 3'd2;
    localparam logic [2:0] PH_SEC = 3'd3;
    localparam logic [2:0] PH_TEXT = 3'd4;
    localparam logic [2:0] PH_REJECT = 3'd5;

    localparam logic [1:0] NM_SKIP = 2'd0;
    localparam logic [1:0] NM_SIGN = 2'd1;
    localparam logic [1:0] NM_DIG = 2'd2;
    localparam logic [1:0] NM_DONE = 2'd3;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0] mode;
        logic neg;
    } num_t;

    typedef struct packed {
        logic seen;
        logic at_zero;
        logic [1:0] len;
        num_t num;
    } frac_t;

    // One finished line handed from the front to the back.
    typedef struct packed {
        logic [31:0] minutes;
        logic [31:0] seconds;
        logic [9:0] frac;
        logic frac_neg;
        logic [1:0] frac_len;
        logic frac_zero;
        logic [7:0] text_start;
        logic [7:0] text_length;
        logic [15:0] line_number;
        logic too_long;
        logic last;
    } line_t;

    function automatic logic is_ws(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic num_t num_feed(input num_t n, input logic [7:0] c);
        num_t r;
        logic [31:0] d;
        r = n;
        d = {28'd0, c[3:0]};
        case (n.mode)
            NM_SKIP:
            begin
                if (is_ws(c))
                    r = n;
                else if (c == 8'h2B || c == 8'h2D)
                begin
                    r.neg = (c == 8'h2D);
                    r.mode = NM_SIGN;
                end
                else if (is_digit(c))
                begin
                    r.value = d;
                    r.mode = NM_DIG;
                end
                else
                    r.mode = NM_DONE;
            end
            NM_SIGN, NM_DIG:
            begin
                if (is_digit(c))
                begin
                    r.value = (n.value << 3) + (n.value << 1) + d;
                    r.mode = NM_DIG;
                end
                else
                    r.mode = NM_DONE;
            end
            default: r = n;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] num_result(input num_t n);
        return n.neg ? (32'd0 - n.value) : n.value;
    endfunction
endpackage

@@ rtl/lrc_timestamp_line_parser_core.sv @@
// Top level of the LRC timestamp line parser.
// Depends on lrc_pkg, lrc_front, lrc_queue and lrc_back.
//
// Channel  Dir  Fields
// s_axis   in   tdata = text_byte, tlast = end_of_text
// m_axis   out  tdata = timestamp_ms, text_start, text_length, line_number;
//               tuser = too_long, tlast = last
//
// The scanner takes one byte per cycle while the line queue has room.
// Each accepted line passes through the time unit in two multiply steps and the
// output beat; the time unit takes the next line only after that beat is accepted.
// The scanner stalls only while the queue is full.
// Reset is asynchronous and active low and empties queue and scanner.
`timescale 1ns / 1ps
module lrc_timestamp_line_parser_core (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // text_byte
    input  logic s_axis_tlast,        // end_of_text
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [63:0] m_axis_tdata, // timestamp_ms, text_start, text_length, line_number
    output logic m_axis_tuser,        // too_long
    output logic m_axis_tlast         // last
);
    import lrc_pkg::*;

    line_t push_data, pop_data;
    logic push, full, not_empty, pop;

    lrc_front u_front (
        .clk(clk), .rst_n(rst_n),
        .text_byte(s_axis_tdata), .end_of_text(s_axis_tlast),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .line_data(push_data), .line_push(push), .q_full(full)
    );

    lrc_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push_data(push_data), .push(push), .full(full),
        .pop_data(pop_data), .not_empty(not_empty), .pop(pop)
    );

    lrc_back u_back (
        .clk(clk), .rst_n(rst_n),
        .line_data(pop_data), .line_valid(not_empty), .line_pop(pop),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .timestamp_ms(m_axis_tdata[31:0]), .text_start(m_axis_tdata[39:32]),
        .text_length(m_axis_tdata[47:40]), .line_number(m_axis_tdata[63:48]),
        .too_long(m_axis_tuser), .last(m_axis_tlast)
    );
endmodule

@@ rtl/lrc_front.sv @@
// Front part: per-byte line scanner that builds one line record per accepted line.
// Depends on lrc_pkg.
`timescale 1ns / 1ps
module lrc_front (
    input  logic clk,
    input  logic rst_n,
    input  logic [7:0] text_byte,
    input  logic end_of_text,
    input  logic in_valid,
    output logic in_ready,
    output lrc_pkg::line_t line_data,
    output logic line_push,
    input  logic q_full
);
    import lrc_pkg::*;

    logic [2:0] phase_reg, phase_next;
    logic [PosW-1:0] pos_reg, pos_next;
    logic over_reg, over_next;
    num_t min_reg, min_next, sec_reg, sec_next;
    logic chars_reg, chars_next;
    frac_t dot_reg, dot_next, com_reg, com_next;
    logic seen_reg, seen_next;
    logic [PosW-1:0] first_reg, first_next, end_reg, end_next;
    logic [LineCountWidth-1:0] cnt_reg, cnt_next;
    logic take, is_nl, finish, hit;
    frac_t fsel;
    logic [7:0] len8;

    assign in_ready = !q_full;
    assign take = in_valid && in_ready;
    assign is_nl = text_byte == 8'd10;
    assign finish = take && (is_nl || end_of_text);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        over_next = over_reg;
        min_next = min_reg;
        sec_next = sec_reg;
        chars_next = chars_reg;
        dot_next = dot_reg;
        com_next = com_reg;
        seen_next = seen_reg;
        first_next = first_reg;
        end_next = end_reg;
        cnt_next = cnt_reg;
        if (take && !is_nl)
        begin
            if (pos_reg < PosW'(MaxLineLen))
                pos_next = pos_reg + 1'b1;
            else
                over_next = 1'b1;
            case (phase_reg)
                PH_LEAD:
                    if (!is_ws(text_byte))
                        phase_next = (text_byte == 8'h5B) ? PH_FIRST : PH_REJECT;
                PH_FIRST:
                    if (is_digit(text_byte))
                    begin
                        min_next = num_feed(min_reg, text_byte);
                        phase_next = PH_MIN;
                    end
                    else
                        phase_next = PH_REJECT;
                PH_MIN:
                    if (text_byte == 8'h5D)
                        phase_next = PH_REJECT;
                    else if (text_byte == 8'h3A)
                        phase_next = PH_SEC;
                    else
                        min_next = num_feed(min_reg, text_byte);
                PH_SEC:
                    if (text_byte == 8'h5D)
                        phase_next = PH_TEXT;
                    else
                    begin
                        sec_next = num_feed(sec_reg, text_byte);
                        if (dot_reg.seen)
                        begin
                            if (dot_reg.len != 2'd3)
                            begin
                                dot_next.num = num_feed(dot_reg.num, text_byte);
                                dot_next.len = dot_reg.len + 2'd1;
                            end
                        end
                        else if (text_byte == 8'h2E)
                        begin
                            dot_next.seen = 1'b1;
                            dot_next.at_zero = !chars_reg;
                        end
                        if (com_reg.seen)
                        begin
                            if (com_reg.len != 2'd3)
                            begin
                                com_next.num = num_feed(com_reg.num, text_byte);
                                com_next.len = com_reg.len + 2'd1;
                            end
                        end
                        else if (text_byte == 8'h2C)
                        begin
                            com_next.seen = 1'b1;
                            com_next.at_zero = !chars_reg;
                        end
                        chars_next = 1'b1;
                    end
                PH_TEXT:
                    if (!is_ws(text_byte))
                    begin
                        if (!seen_reg)
                        begin
                            seen_next = 1'b1;
                            first_next = pos_reg;
                        end
                        end_next = (pos_reg < PosW'(MaxLineLen)) ? pos_reg + 1'b1
                                                                 : PosW'(MaxLineLen);
                    end
                default: phase_next = phase_reg;
            endcase
        end
        if (finish)
        begin
            if (phase_next == PH_TEXT)
                cnt_next = cnt_reg + 1'b1;
            if (end_of_text)
                cnt_next = '0;
        end
    end

    assign hit = phase_next == PH_TEXT;
    assign fsel = dot_next.seen ? dot_next : com_next;
    assign len8 = end_next - first_next;

    always_comb
    begin
        line_data.minutes = num_result(min_next);
        line_data.seconds = num_result(sec_next);
        line_data.frac = fsel.num.value[9:0];
        line_data.frac_neg = fsel.num.neg;
        line_data.frac_len = fsel.len;
        line_data.frac_zero = !fsel.seen || fsel.at_zero;
        line_data.text_start = seen_next ? first_next : 8'd0;
        line_data.text_length = seen_next ? len8 : 8'd0;
        line_data.line_number = 16'(cnt_reg);
        line_data.too_long = over_next;
        line_data.last = end_of_text;
    end
    assign line_push = finish && hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            pos_reg <= '0;
            over_reg <= 1'b0;
            min_reg <= '0;
            sec_reg <= '0;
            chars_reg <= 1'b0;
            dot_reg <= '0;
            com_reg <= '0;
            seen_reg <= 1'b0;
            first_reg <= '0;
            end_reg <= '0;
            cnt_reg <= '0;
        end
        else if (finish)
        begin
            phase_reg <= PH_LEAD;
            pos_reg <= '0;
            over_reg <= 1'b0;
            min_reg <= '0;
            sec_reg <= '0;
            chars_reg <= 1'b0;
            dot_reg <= '0;
            com_reg <= '0;
            seen_reg <= 1'b0;
            first_reg <= '0;
            end_reg <= '0;
            cnt_reg <= cnt_next;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            over_reg <= over_next;
            min_reg <= min_next;
            sec_reg <= sec_next;
            chars_reg <= chars_next;
            dot_reg <= dot_next;
            com_reg <= com_next;
            seen_reg <= seen_next;
            first_reg <= first_next;
            end_reg <= end_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

@@ rtl/lrc_queue.sv @@
// Two-entry queue of line records between the scanner and the time unit.
// Depends on lrc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lrc_queue (
    input  logic clk,
    input  logic rst_n,
    input  lrc_pkg::line_t push_data,
    input  logic push,
    output logic full,
    output lrc_pkg::line_t pop_data,
    output logic not_empty,
    input  logic pop
);
    import lrc_pkg::*;

    line_t mem_reg [QDepth];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full = cnt_reg == 2'(QDepth);
    assign not_empty = cnt_reg != 2'd0;
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    `ASSERT_CLK(a_no_overflow, !(push && full), "push into full queue")
    `ASSERT_CLK(a_no_underflow, !(pop && !not_empty), "pop from empty queue")
    `ASSERT_NEXT(a_count_up, push && !pop, cnt_reg == $past(cnt_reg) + 2'd1, "count slip")
endmodule

@@ rtl/lrc_back.sv @@
// Back part: computes the millisecond time of a line in a load step, a multiply step and an output state.
// Depends on lrc_pkg.
`timescale 1ns / 1ps
module lrc_back (
    input  logic clk,
    input  logic rst_n,
    input  lrc_pkg::line_t line_data,
    input  logic line_valid,
    output logic line_pop,
    output logic out_valid,
    input  logic out_ready,
    output logic [31:0] timestamp_ms,
    output logic [7:0] text_start,
    output logic [7:0] text_length,
    output logic [15:0] line_number,
    output logic too_long,
    output logic last
);
    import lrc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;

    logic [1:0] st_reg;
    line_t cur_reg;
    logic [31:0] acc_reg, fms;

    assign line_pop = (st_reg == ST_IDLE) && line_valid;
    assign out_valid = st_reg == ST_OUT;

    always_comb
    begin
        case (cur_reg.frac_len)
            2'd1: fms = {22'd0, cur_reg.frac} * 32'd100;
            2'd2: fms = {22'd0, cur_reg.frac} * 32'd10;
            2'd3: fms = {22'd0, cur_reg.frac};
            default: fms = 32'd0;
        endcase
        if (cur_reg.frac_neg)
            fms = 32'd0 - fms;
        if (cur_reg.frac_zero)
            fms = 32'd0;
    end

    always_ff @(posedge clk)
    begin
        if (line_pop)
        begin
            cur_reg <= line_data;
            acc_reg <= line_data.minutes * 32'd60 + line_data.seconds;
        end
        else if (st_reg == ST_MUL)
            acc_reg <= acc_reg * 32'd1000 + fms;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ST_IDLE;
        else
        begin
            case (st_reg)
                ST_IDLE: if (line_valid) st_reg <= ST_MUL;
                ST_MUL: st_reg <= ST_OUT;
                ST_OUT: if (out_ready) st_reg <= ST_IDLE;
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assign timestamp_ms = acc_reg;
    assign text_start = cur_reg.text_start;
    assign text_length = cur_reg.text_length;
    assign line_number = cur_reg.line_number;
    assign too_long = cur_reg.too_long;
    assign last = cur_reg.last;
endmodule
